// ===== rtl/srrq_pkg.sv =====
// ----------------------------------------------------------------------------
// srrq_pkg
// Shared types and codes for the sample ring with range query unit.
// ----------------------------------------------------------------------------
package srrq_pkg;

  localparam logic [2:0] REQ_PUSH   = 3'd0;
  localparam logic [2:0] REQ_GET    = 3'd1;
  localparam logic [2:0] REQ_LATEST = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_QUERY  = 3'd4;

  // restoring divider for the query stride
  localparam int         QUOT_W    = 10;
  localparam logic [3:0] DIV_STEPS = 4'd10;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] sample_value;
    logic [31:0] sample_time;
    logic [7:0]  age_index;
    logic [31:0] from_time;
    logic [31:0] to_time;
    logic [6:0]  out_max;
  } req_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] out_value;
    logic [31:0] out_time;
    logic        sample_valid;
    logic [8:0]  fill_count;
    logic        ring_full;
    logic        last;
    logic [6:0]  returned_count;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_CNT_TEST,
    S_CNT_RD,
    S_CNT_CHK,
    S_DIV,
    S_SEL_TEST,
    S_SEL_RD,
    S_SEL_CHK
  } ctrl_state_t;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_ACCEPT,
    OP_EMIT_READ,
    OP_COUNT,
    OP_EMIT_NOMATCH,
    OP_DIV_START,
    OP_DIV_STEP,
    OP_SELECT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic acc_read;
    logic acc_query;
    logic walk_more;
    logic match_zero;
    logic div_last;
    logic sel_more;
  } dp_status_t;

endpackage

// ===== rtl/srrq_ram.sv =====
// ----------------------------------------------------------------------------
// srrq_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module srrq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/srrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// srrq_ctrl
// Sequencer: accepts requests and steps the datapath through reads,
// the counting walk, the stride division and the selecting walk.
// ----------------------------------------------------------------------------
module srrq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  srrq_pkg::dp_status_t status,
  output srrq_pkg::dp_cmd_t    cmd
);

  import srrq_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd.op     = OP_IDLE;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.op = OP_ACCEPT;
          if (status.acc_read) begin
            state_next = S_READ;
          end else if (status.acc_query) begin
            state_next = S_CNT_TEST;
          end
        end
      end
      S_READ: begin
        cmd.op     = OP_EMIT_READ;
        state_next = S_IDLE;
      end
      S_CNT_TEST: begin
        if (status.walk_more) begin
          state_next = S_CNT_RD;
        end else if (status.match_zero) begin
          cmd.op     = OP_EMIT_NOMATCH;
          state_next = S_IDLE;
        end else begin
          cmd.op     = OP_DIV_START;
          state_next = S_DIV;
        end
      end
      S_CNT_RD: begin
        state_next = S_CNT_CHK;
      end
      S_CNT_CHK: begin
        cmd.op     = OP_COUNT;
        state_next = S_CNT_TEST;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = S_SEL_TEST;
        end
      end
      S_SEL_TEST: begin
        state_next = status.sel_more ? S_SEL_RD : S_IDLE;
      end
      S_SEL_RD: begin
        state_next = S_SEL_CHK;
      end
      S_SEL_CHK: begin
        cmd.op     = OP_SELECT;
        state_next = S_SEL_TEST;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ===== rtl/srrq_dp.sv =====
// ----------------------------------------------------------------------------
// srrq_dp
// Ring datapath: sample memory, ring pointers, walk counters, stride
// divider and result register.
// ----------------------------------------------------------------------------
module srrq_dp #(
  parameter int DEPTH      = 256,
  parameter int MAX_RETURN = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  srrq_pkg::req_t       req,
  input  srrq_pkg::dp_cmd_t    cmd,
  output srrq_pkg::dp_status_t status,
  input  logic                 cfg_wr,
  input  logic [8:0]           cfg_data,
  output logic [8:0]           capacity,
  output logic                 done,
  output srrq_pkg::res_t       result
);

  import srrq_pkg::*;

  localparam int         MEM_DEPTH  = (DEPTH < 511) ? DEPTH : 511;
  localparam int         AW         = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam logic [8:0] CAP_LIMIT  = 9'(MEM_DEPTH);
  localparam logic [8:0] CAP_RESET  = 9'((DEPTH < 256) ? DEPTH : 256);
  localparam logic [6:0] OMAX_LIMIT = 7'(MAX_RETURN);

  function automatic res_t make_res(input logic ok, input logic has,
                                    input logic [31:0] value,
                                    input logic [31:0] tstamp,
                                    input logic [8:0] fill, input logic full,
                                    input logic last, input logic [6:0] ret);
    res_t r;
    r.ok             = ok;
    r.out_value      = has ? value : 32'd0;
    r.out_time       = has ? tstamp : 32'd0;
    r.sample_valid   = has;
    r.fill_count     = fill;
    r.ring_full      = full;
    r.last           = last;
    r.returned_count = ret;
    return r;
  endfunction

  logic [8:0]        cap, cap_next;
  logic [8:0]        wpos, wpos_next;
  logic [8:0]        vcount, vcount_next;
  logic [31:0]       lo, hi;
  logic [6:0]        omax;
  logic [8:0]        walk_idx, walk_idx_next;
  logic [8:0]        walk_slot, walk_slot_next;
  logic [8:0]        match_total, match_total_next;
  logic [8:0]        match_pos, match_pos_next;
  logic [8:0]        phase, phase_next;
  logic [6:0]        written, written_next;
  logic              sel_done, sel_done_next;
  logic [QUOT_W-1:0] quot, quot_next;
  logic [6:0]        rem, rem_next;
  logic [3:0]        dcnt, dcnt_next;
  logic              done_next;
  res_t              res_next;

  logic [8:0]  start_slot, get_slot, latest_slot, wpos_inc, slot_inc;
  logic [9:0]  age_sum;
  logic [8:0]  rd_addr;
  logic [6:0]  omax_sat;
  logic [63:0] rdata;
  logic [31:0] rd_value, rd_time;
  logic        hit, get_ok, latest_ok, ram_we, sel_last;
  logic [7:0]  trial;
  logic        ge;

  assign start_slot  = (vcount < cap) ? 9'd0 : wpos;
  assign age_sum     = {1'b0, start_slot} + {2'b00, req.age_index};
  assign get_slot    = (age_sum >= {1'b0, cap}) ? 9'(age_sum - {1'b0, cap}) : age_sum[8:0];
  assign latest_slot = (wpos == 9'd0) ? cap - 9'd1 : wpos - 9'd1;
  assign get_ok      = ({1'b0, req.age_index} < vcount);
  assign latest_ok   = (vcount != 9'd0);
  assign wpos_inc    = (wpos + 9'd1 == cap) ? 9'd0 : wpos + 9'd1;
  assign slot_inc    = (walk_slot + 9'd1 == cap) ? 9'd0 : walk_slot + 9'd1;
  assign omax_sat    = (req.out_max > OMAX_LIMIT) ? OMAX_LIMIT : req.out_max;

  assign rd_addr = (cmd.op == OP_ACCEPT) ?
                   ((req.req_type == REQ_LATEST) ? latest_slot : get_slot) : walk_slot;
  assign ram_we  = (cmd.op == OP_ACCEPT) && (req.req_type == REQ_PUSH);

  srrq_ram #(
    .WIDTH (64),
    .DEPTH (MEM_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wpos[AW-1:0]),
    .wdata ({req.sample_value, req.sample_time}),
    .raddr (rd_addr[AW-1:0]),
    .rdata (rdata)
  );

  assign rd_value = rdata[63:32];
  assign rd_time  = rdata[31:0];
  assign hit      = ((lo == 32'd0) || (rd_time >= lo)) && ((hi == 32'd0) || (rd_time <= hi));

  // one quotient bit per step, numerator shifts out of quot as bits shift in
  assign trial = {rem, quot[QUOT_W-1]};
  assign ge    = (trial >= {1'b0, omax});

  // a selected sample is the final one when out_max is reached or fewer
  // than one stride of matches remain
  assign sel_last = (written + 7'd1 == omax) ||
                    ({1'b0, match_pos} + {1'b0, quot[8:0]} >= {1'b0, match_total});

  always_comb begin
    cap_next         = cap;
    wpos_next        = wpos;
    vcount_next      = vcount;
    walk_idx_next    = walk_idx;
    walk_slot_next   = walk_slot;
    match_total_next = match_total;
    match_pos_next   = match_pos;
    phase_next       = phase;
    written_next     = written;
    sel_done_next    = sel_done;
    quot_next        = quot;
    rem_next         = rem;
    dcnt_next        = dcnt;
    done_next        = 1'b0;
    res_next         = result;

    if (cfg_wr && (cfg_data != 9'd0) && (cfg_data <= CAP_LIMIT)) begin
      cap_next    = cfg_data;
      wpos_next   = 9'd0;
      vcount_next = 9'd0;
    end

    unique case (cmd.op)
      OP_ACCEPT: begin
        if (req.req_type == REQ_PUSH) begin
          wpos_next = wpos_inc;
          if (vcount < cap) begin
            vcount_next = vcount + 9'd1;
          end
        end else if (req.req_type == REQ_CLEAR) begin
          wpos_next   = 9'd0;
          vcount_next = 9'd0;
        end
        walk_idx_next    = 9'd0;
        walk_slot_next   = start_slot;
        match_total_next = 9'd0;
        if (!status.acc_read && !status.acc_query) begin
          done_next = 1'b1;
          res_next  = make_res((req.req_type == REQ_PUSH) || (req.req_type == REQ_CLEAR),
                               1'b0, 32'd0, 32'd0, vcount_next,
                               vcount_next >= cap_next, 1'b1, 7'd0);
        end
      end
      OP_EMIT_READ: begin
        done_next = 1'b1;
        res_next  = make_res(1'b1, 1'b1, rd_value, rd_time, vcount, vcount >= cap,
                             1'b1, 7'd0);
      end
      OP_COUNT: begin
        if (hit) begin
          match_total_next = match_total + 9'd1;
        end
        walk_idx_next  = walk_idx + 9'd1;
        walk_slot_next = slot_inc;
      end
      OP_EMIT_NOMATCH: begin
        done_next = 1'b1;
        res_next  = make_res(1'b1, 1'b0, 32'd0, 32'd0, vcount, vcount >= cap,
                             1'b1, 7'd0);
      end
      OP_DIV_START: begin
        // ceiling via (matches + out_max - 1) / out_max
        quot_next      = {1'b0, match_total} + {3'b000, omax} - 10'd1;
        rem_next       = 7'd0;
        dcnt_next      = DIV_STEPS;
        walk_idx_next  = 9'd0;
        walk_slot_next = start_slot;
        match_pos_next = 9'd0;
        phase_next     = 9'd0;
        written_next   = 7'd0;
        sel_done_next  = 1'b0;
      end
      OP_DIV_STEP: begin
        rem_next  = ge ? 7'(trial - {1'b0, omax}) : trial[6:0];
        quot_next = {quot[QUOT_W-2:0], ge};
        dcnt_next = dcnt - 4'd1;
      end
      OP_SELECT: begin
        if (hit) begin
          if (phase == 9'd0) begin
            done_next     = 1'b1;
            res_next      = make_res(1'b1, 1'b1, rd_value, rd_time, vcount,
                                     vcount >= cap, sel_last, written + 7'd1);
            written_next  = written + 7'd1;
            sel_done_next = sel_last;
          end
          phase_next     = (phase + 9'd1 == quot[8:0]) ? 9'd0 : phase + 9'd1;
          match_pos_next = match_pos + 9'd1;
        end
        walk_idx_next  = walk_idx + 9'd1;
        walk_slot_next = slot_inc;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cap         <= CAP_RESET;
      wpos        <= 9'd0;
      vcount      <= 9'd0;
      walk_idx    <= 9'd0;
      walk_slot   <= 9'd0;
      match_total <= 9'd0;
      match_pos   <= 9'd0;
      phase       <= 9'd0;
      written     <= 7'd0;
      sel_done    <= 1'b0;
      dcnt        <= 4'd0;
      done        <= 1'b0;
    end else begin
      cap         <= cap_next;
      wpos        <= wpos_next;
      vcount      <= vcount_next;
      walk_idx    <= walk_idx_next;
      walk_slot   <= walk_slot_next;
      match_total <= match_total_next;
      match_pos   <= match_pos_next;
      phase       <= phase_next;
      written     <= written_next;
      sel_done    <= sel_done_next;
      dcnt        <= dcnt_next;
      done        <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    quot   <= quot_next;
    rem    <= rem_next;
    result <= res_next;
    if (cmd.op == OP_ACCEPT) begin
      lo   <= req.from_time;
      hi   <= req.to_time;
      omax <= omax_sat;
    end
  end

  assign capacity = cap;

  assign status.acc_read   = ((req.req_type == REQ_GET) && get_ok) ||
                             ((req.req_type == REQ_LATEST) && latest_ok);
  assign status.acc_query  = (req.req_type == REQ_QUERY) && (req.out_max != 7'd0);
  assign status.walk_more  = (walk_idx < vcount);
  assign status.match_zero = (match_total == 9'd0);
  assign status.div_last   = (dcnt == 4'd1);
  assign status.sel_more   = (walk_idx < vcount) && !sel_done;

endmodule

// ===== rtl/sample_ring_with_range_query_unit.sv =====
// ----------------------------------------------------------------------------
// sample_ring_with_range_query_unit
// Overwriting ring of timestamped samples with get, latest, clear and a
// downsampling range query.
// ----------------------------------------------------------------------------
// channel   signals                               direction
// request   start, busy, req                      in (accepted on start & !busy)
// result    done, result                          out (one cycle, no back-pressure)
// config    psel penable pwrite paddr pwdata ...  apb, ring_capacity at 0x0
//
// push, clear and failed requests finish in the accept state; get and latest
// pass through a read state for the registered memory read. a range query
// walks the ring once to count matches and, if any match, runs the stride
// divider and walks again to select; each sample takes a test, read and check
// state on one read port. results of a query come one per selected sample.
// reset is synchronous; the ring comes up empty with capacity min(DEPTH, 256).
// results are not stalled: the receiver must take each one when done is high.
// ----------------------------------------------------------------------------
module sample_ring_with_range_query_unit #(
  parameter int DEPTH      = 256,
  parameter int MAX_RETURN = 64
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  srrq_pkg::req_t  req,
  output logic            done,
  output srrq_pkg::res_t  result,
  input  logic            psel,
  input  logic            penable,
  input  logic            pwrite,
  input  logic [2:0]      paddr,
  input  logic [31:0]     pwdata,
  output logic [31:0]     prdata,
  output logic            pready
);

  import srrq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;
  logic       cfg_wr;
  logic [8:0] capacity;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && !paddr[2];
  assign prdata = paddr[2] ? 32'd0 : {23'd0, capacity};

  srrq_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  srrq_dp #(
    .DEPTH      (DEPTH),
    .MAX_RETURN (MAX_RETURN)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .req      (req),
    .cmd      (cmd),
    .status   (status),
    .cfg_wr   (cfg_wr),
    .cfg_data (pwdata[8:0]),
    .capacity (capacity),
    .done     (done),
    .result   (result)
  );

endmodule
